// ----- sv/eled_pkg.sv -----
// ----------------------------------------------------------------------------
// Echoing line editor package
// Shared types, byte codes and defaults for the echoing line editor.
// ----------------------------------------------------------------------------
package eled_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 6;

	// Default store depth and default character limit after reset.
	localparam int                 DEF_CAPACITY  = 32;
	localparam logic [COUNT_W-1:0] DEF_MAX_CHARS = 6'd32;

	// Terminal byte codes.
	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

	// Result kinds as they appear on the output tuser.
	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_CHAR = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	// Echo sequence being played out.
	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_BS,
		CMD_EOL
	} cmd_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ECHO,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_END
	} state_t;

	// One result item handed from the controller to the output register.
	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data;
		logic [COUNT_W-1:0] len;
		logic               last;
	} res_t;

endpackage

// ----- sv/eled_store.sv -----
// ----------------------------------------------------------------------------
// Line store
// Synchronous single-write, single-read memory holding the typed characters.
// ----------------------------------------------------------------------------
module eled_store
	import eled_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AddrW-1:0]  waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AddrW-1:0]  raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [CAPACITY];
	logic [BYTE_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

// ----- sv/eled_ctrl.sv -----
// ----------------------------------------------------------------------------
// Line editor controller
// Decodes received bytes, keeps the character count and sequences results.
// ----------------------------------------------------------------------------
module eled_ctrl
	import eled_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic [COUNT_W-1:0] limit,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	output logic               mem_we,
	output logic [AddrW-1:0]   mem_waddr,
	output logic [BYTE_W-1:0]  mem_wdata,
	output logic               mem_re,
	output logic [AddrW-1:0]   mem_raddr,
	input  logic [BYTE_W-1:0]  mem_rdata
);

	localparam logic [COUNT_W-1:0] CapCount = COUNT_W'(CAPACITY);

	state_t             state_q, state_d;
	cmd_t               cmd_q, cmd_d;
	logic [1:0]         idx_q, idx_d;
	logic [BYTE_W-1:0]  byte_q, byte_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] ptr_q, ptr_d;
	logic [COUNT_W-1:0] ptr_inc;
	logic               is_eol, is_erase, is_print;

	// Byte classification.
	assign is_eol   = (in_byte == CH_CR) || (in_byte == CH_LF);
	assign is_erase = (in_byte == CH_BS) || (in_byte == CH_DEL);
	assign is_print = (in_byte >= CH_SP) && (in_byte < CH_DEL);
	assign ptr_inc  = COUNT_W'(ptr_q + 6'd1);

	// Memory addressing: writes append at the count, reads walk the pointer.
	assign mem_waddr = count_q[AddrW-1:0];
	assign mem_wdata = in_byte;
	assign mem_raddr = ptr_q[AddrW-1:0];

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_CHAR;
			idx_q   <= 2'd0;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			cmd_q   <= cmd_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
		end
	end

	// The echoed byte needs no reset.
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

	// Next state and result generation.
	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		idx_d     = idx_q;
		byte_d    = byte_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '{kind: KIND_ECHO, data: '0, len: '0, last: 1'b0};
		mem_we    = 1'b0;
		mem_re    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				idx_d    = 2'd0;
				if (in_valid) begin
					if (is_eol) begin
						cmd_d   = CMD_EOL;
						state_d = ST_ECHO;
					end else if (is_erase && (count_q != '0)) begin
						cmd_d   = CMD_BS;
						count_d = COUNT_W'(count_q - 6'd1);
						state_d = ST_ECHO;
					end else if (is_print && (count_q < limit)) begin
						mem_we  = 1'b1;
						count_d = COUNT_W'(count_q + 6'd1);
						cmd_d   = CMD_CHAR;
						byte_d  = in_byte;
						state_d = ST_ECHO;
					end
				end
			end

			ST_ECHO: begin
				res_valid = 1'b1;
				case (cmd_q)
					CMD_CHAR: begin
						res.data = byte_q;
						res.last = 1'b1;
					end
					CMD_BS: begin
						res.data = (idx_q == 2'd1) ? CH_SP : CH_BS;
						res.last = (idx_q == 2'd2);
					end
					default: begin
						res.data = (idx_q == 2'd0) ? CH_CR : CH_LF;
					end
				endcase
				if (res_ready) begin
					idx_d = 2'(idx_q + 2'd1);
					if (cmd_q == CMD_CHAR) begin
						state_d = ST_IDLE;
					end else if (cmd_q == CMD_BS) begin
						if (idx_q == 2'd2) begin
							state_d = ST_IDLE;
						end
					end else if (idx_q == 2'd1) begin
						ptr_d   = '0;
						state_d = (count_q == '0) ? ST_END : ST_RD_ADDR;
					end
				end
			end

			ST_RD_ADDR: begin
				mem_re  = 1'b1;
				state_d = ST_RD_DATA;
			end

			ST_RD_DATA: begin
				res_valid = 1'b1;
				res.kind  = KIND_CHAR;
				res.data  = mem_rdata;
				if (res_ready) begin
					ptr_d   = ptr_inc;
					state_d = (ptr_inc == count_q) ? ST_END : ST_RD_ADDR;
				end
			end

			ST_END: begin
				res_valid = 1'b1;
				res.kind  = KIND_END;
				res.len   = count_q;
				res.last  = 1'b1;
				if (res_ready) begin
					count_d = '0;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The count never passes the store depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CapCount)
		else $error("character count exceeds store capacity");

	// Reads only touch entries that were written for the current line.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_ADDR || state_q == ST_RD_DATA) |-> ptr_q < count_q)
		else $error("line store read beyond character count");

	// A store write always stays within the active limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < limit) && (count_q < CapCount))
		else $error("line store write beyond limit");

	// A line end byte starts the echo sequence on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_eol) |=> (state_q == ST_ECHO && cmd_q == CMD_EOL))
		else $error("line end byte did not start echo");

endmodule

// ----- sv/echoing_line_editor.sv -----
// ----------------------------------------------------------------------------
// Echoing line editor
// Terminal line editing with echo, backspace handling and line streaming.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_axis channel, one transfer per byte. Each
// result leaves on the m_axis channel: tuser carries the kind (echo byte,
// stored line character or line end), tdata the byte and the line length,
// and tlast marks the final result caused by one received byte.
// A printable byte yields one echo result. Backspace or DEL yields three
// echo results, one per cycle when the receiver keeps up. CR or LF yields
// CR, LF, then every stored character and a line-end result; each stored
// character is read in ST_RD_ADDR and shown in ST_RD_DATA because the line
// store has one registered read port. A byte that causes no result is
// simply dropped. One byte is worked on at a time: s_axis_tready is low
// until the last result of the previous byte has entered the output register.
// A stall on m_axis_tready holds the output register and the sequencer.
// Reset clears the character count and sets the limit to 32; the store
// itself needs no clearing. cfg_wr_en writes the limit; the user must do so
// while idle only, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module echoing_line_editor
	import eled_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [15:0]        m_axis_tdata,   // [7:0] data_byte, [13:8] line_length
	output logic [1:0]         m_axis_tuser,   // [1:0] kind
	output logic               m_axis_tlast,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data     // max_chars
);

	localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [COUNT_W-1:0] CapCount = COUNT_W'(CAPACITY);

	logic [COUNT_W-1:0] max_chars_q;
	logic [COUNT_W-1:0] limit;
	logic               res_valid, res_ready;
	res_t               res;
	logic               out_valid_q;
	res_t               out_res_q;
	logic               mem_we, mem_re;
	logic [AddrW-1:0]   mem_waddr, mem_raddr;
	logic [BYTE_W-1:0]  mem_wdata, mem_rdata;

	// Limit register and effective limit bounded by the store depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= DEF_MAX_CHARS;
		end else if (cfg_wr_en) begin
			max_chars_q <= cfg_wr_data;
		end
	end

	assign limit = (max_chars_q < CapCount) ? max_chars_q : CapCount;

	eled_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.limit     (limit),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	eled_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: loads when empty or when its result is being taken.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_res_q.len, out_res_q.data};
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tlast  = out_res_q.last;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Echoing line editor testbench
// Drives received bytes into the editor, predicts every echo, line character
// and line-end result, and checks each result transfer in arrival order.
// Directed bytes and limit corner cases come first, then randomly built
// lines under four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	import eled_pkg::*;

	localparam int CAP          = DEF_CAPACITY;
	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 8;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;   // [7:0] rx_byte
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [15:0]        m_axis_tdata;   // [7:0] data_byte, [13:8] line_length
	logic [1:0]         m_axis_tuser;   // [1:0] kind
	logic               m_axis_tlast;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;    // max_chars

	// Predicted editor state and the results still to come.
	logic [7:0]  line_copy [0:CAP-1];
	int unsigned line_count;
	int unsigned char_limit;
	res_t        pending_results [$];
	res_t        oldest_result;

	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct;
	int stall_pct;
	int line_bytes_sent;

	echoing_line_editor #(
		.CAPACITY(CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver backpressure, redrawn each cycle.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Works out the results that one received byte causes and queues them.
	function automatic void predict_rx_byte(input logic [7:0] rx);
		res_t        batch [$];
		res_t        item;
		int unsigned eff_limit;
		int unsigned i;
		eff_limit = (char_limit < CAP) ? char_limit : CAP;
		item = '0;
		if (rx == CH_CR || rx == CH_LF) begin
			item.kind = KIND_ECHO;
			item.data = CH_CR;
			batch.push_back(item);
			item.data = CH_LF;
			batch.push_back(item);
			for (i = 0; i < line_count; i++) begin
				item.kind = KIND_CHAR;
				item.data = line_copy[i];
				batch.push_back(item);
			end
			item.kind = KIND_END;
			item.data = '0;
			item.len  = line_count[COUNT_W-1:0];
			batch.push_back(item);
			line_count = 0;
		end else if ((rx == CH_BS || rx == CH_DEL) && line_count > 0) begin
			// Rub-out: step back, overwrite with a space, step back again.
			item.kind = KIND_ECHO;
			item.data = CH_BS;
			batch.push_back(item);
			item.data = CH_SP;
			batch.push_back(item);
			item.data = CH_BS;
			batch.push_back(item);
			line_count--;
		end else if (rx >= CH_SP && rx < CH_DEL && line_count < eff_limit) begin
			line_copy[line_count] = rx;
			line_count++;
			item.kind = KIND_ECHO;
			item.data = rx;
			batch.push_back(item);
		end
		if (batch.size() > 0) begin
			batch[batch.size()-1].last = 1'b1;
		end
		foreach (batch[k]) begin
			pending_results.push_back(batch[k]);
		end
	endfunction

	// Result checker: each output transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d data %h length %0d last %0b",
					m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tlast);
				error_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (m_axis_tuser !== oldest_result.kind) begin
					$error("kind: expected %0d, got %0d", oldest_result.kind, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[7:0] !== oldest_result.data) begin
					$error("data_byte: expected %h, got %h",
						oldest_result.data, m_axis_tdata[7:0]);
					error_count++;
				end
				if (m_axis_tdata[13:8] !== oldest_result.len) begin
					$error("line_length: expected %0d, got %0d",
						oldest_result.len, m_axis_tdata[13:8]);
					error_count++;
				end
				if (m_axis_tlast !== oldest_result.last) begin
					$error("last: expected %0b, got %0b", oldest_result.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// Sends one received byte, with random idle cycles ahead of it.
	// Called and left at a falling edge; tvalid stays high on return.
	task automatic send_rx_byte(input logic [7:0] rx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rx;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_rx_byte(rx);
		@(negedge clk);
	endtask

	// Holds off the sender until every predicted result has come out.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the character limit once the editor is idle.
	task automatic write_max_chars(input logic [COUNT_W-1:0] value);
		wait_for_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		char_limit = value;
		@(negedge clk);
	endtask

	// Edge bytes at the reset limit: printable extremes, rub-outs on a
	// filled and on an empty line, control bytes and high bytes.
	task automatic test_directed_bytes();
		logic [7:0] seq [$];
		seq = '{CH_CR, 8'h41, 8'h20, 8'h7E, CH_BS, CH_DEL, CH_DEL, CH_BS, CH_BS,
			8'h00, 8'hFF, 8'h80, 8'h1F, 8'h09, 8'h1B, 8'h78, 8'h5F, CH_LF};
		foreach (seq[k]) begin
			send_rx_byte(seq[k]);
		end
		wait_for_results();
	endtask

	// Character limits: zero, above the store depth, one, and the default.
	task automatic test_line_limits();
		int k;
		write_max_chars('0);
		send_rx_byte(8'h61);
		send_rx_byte(8'h7E);
		send_rx_byte(CH_CR);

		// A limit above the depth is clipped to the store size.
		write_max_chars('1);
		for (k = 0; k < CAP + 2; k++) begin
			send_rx_byte(8'($urandom_range(32, 126)));
		end
		send_rx_byte(CH_LF);
		for (k = 0; k < CAP + 1; k++) begin
			send_rx_byte(8'($urandom_range(32, 126)));
		end
		send_rx_byte(CH_DEL);
		send_rx_byte(CH_CR);

		write_max_chars(6'd1);
		send_rx_byte(8'h71);
		send_rx_byte(8'h72);
		send_rx_byte(CH_DEL);
		send_rx_byte(8'h73);
		send_rx_byte(CH_CR);

		write_max_chars(DEF_MAX_CHARS);
	endtask

	// One randomly built line: mostly printable bytes, some rub-outs and
	// stray bytes, usually closed by CR or LF. Most lines are short.
	task automatic send_random_line();
		int line_len;
		int pick;
		int k;
		line_len = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		for (k = 0; k < line_len; k++) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				send_rx_byte(8'($urandom_range(32, 126)));
				line_bytes_sent++;
			end else if (pick < 93) begin
				send_rx_byte($urandom_range(1) ? CH_BS : CH_DEL);
				line_bytes_sent++;
			end else begin
				send_rx_byte(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(9) != 0) begin
			send_rx_byte($urandom_range(1) ? CH_CR : CH_LF);
			line_bytes_sent++;
		end
	endtask

	// Random lines under four idling patterns, each with its own limit.
	task automatic test_random_lines();
		int phase;
		logic [COUNT_W-1:0] phase_limit;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
					phase_limit   = DEF_MAX_CHARS;
				end
				1: begin
					send_idle_pct = 51;
					stall_pct     = 0;
					phase_limit   = COUNT_W'($urandom_range(1, 8));
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 51;
					phase_limit   = '1;
				end
				default: begin
					send_idle_pct = 25;
					stall_pct     = 25;
					phase_limit   = COUNT_W'($urandom_range(63));
				end
			endcase
			write_max_chars(phase_limit);
			line_bytes_sent = 0;
			send_random_line();
			// The sender waits out the whole output once in every phase.
			wait_for_results();
			while (line_bytes_sent < 55) begin
				send_random_line();
				if ($urandom_range(7) == 0) begin
					wait_for_results();
				end
			end
		end
	endtask

	// Test sequence.
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		line_count    = 0;
		char_limit    = DEF_MAX_CHARS;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_bytes();
		test_line_limits();
		test_random_lines();

		wait_for_results();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
